// ===== sv/scfg_pkg.sv =====
// Shared types, constants and byte functions for the SPI command framer.
package scfg_pkg;

  // Command codes on the action field.
  typedef enum logic [2:0] {
    ACT_REG_WR  = 3'd0,
    ACT_RD_REQ  = 3'd1,
    ACT_SUB_CMD = 3'd2,
    ACT_MEM_WR1 = 3'd3,
    ACT_MEM_WR2 = 3'd4
  } action_e;

  localparam logic [7:0] WriteFlag   = 8'h80;
  localparam logic [7:0] ReadFill    = 8'hFF;
  localparam logic [7:0] CrcPoly     = 8'h07;
  localparam logic [7:0] MbSubLo     = 8'h3E;
  localparam logic [7:0] MbSubHi     = 8'h3F;
  localparam logic [7:0] MbDataLo    = 8'h40;
  localparam logic [7:0] MbDataHi    = 8'h41;
  localparam logic [7:0] MbChecksum  = 8'h60;
  localparam logic [7:0] MbLength    = 8'h61;
  localparam logic [7:0] LenOneByte  = 8'h05;
  localparam logic [7:0] LenTwoByte  = 8'h06;

  // Frame slot within one command's run (at most six frames).
  localparam int unsigned MaxFrames = 6;
  localparam int unsigned IdxW      = $clog2(MaxFrames);
  typedef logic [IdxW-1:0] frame_idx_t;

  // One accepted command word.
  typedef struct packed {
    action_e     action;
    logic [6:0]  reg_address;
    logic [7:0]  reg_byte;
    logic [15:0] sub_address;
    logic [15:0] mem_value;
  } cmd_t;

  // One frame on its way to the result register.
  typedef struct packed {
    logic [7:0] addr_byte;
    logic [7:0] data_byte;
    logic [7:0] crc;
    logic       last;
  } frame_t;

  // CRC-8 of a single byte from a zero start, MSB first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] b);
    logic [7:0] c;
    c = b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  // CRC-8 over address byte then data byte.
  function automatic logic [7:0] crc8_frame(input logic [7:0] a, input logic [7:0] d);
    return crc8_byte(crc8_byte(a) ^ d);
  endfunction

endpackage

// ===== sv/scfg_frame_sel.sv =====
// Frame selection: picks address and data for one frame slot and adds its CRC.
module scfg_frame_sel (
  input  scfg_pkg::cmd_t       cmd_i,
  input  scfg_pkg::frame_idx_t idx_i,
  output scfg_pkg::frame_t     frame_o
);

  logic [7:0] sub_lo, sub_hi, val_lo, val_hi;
  logic [7:0] sum3, sum4;
  logic [7:0] addr_raw, data_byte;
  logic       last;

  assign sub_lo = cmd_i.sub_address[7:0];
  assign sub_hi = cmd_i.sub_address[15:8];
  assign val_lo = cmd_i.mem_value[7:0];
  assign val_hi = cmd_i.mem_value[15:8];

  // Wrapping byte sums for the mailbox checksum.
  assign sum3 = sub_lo + sub_hi + val_lo;
  assign sum4 = sum3 + val_hi;

  // Pick the register and data byte for this slot.
  always_comb begin
    addr_raw  = scfg_pkg::MbSubLo;
    data_byte = sub_lo;
    last      = 1'b0;
    case (cmd_i.action)
      scfg_pkg::ACT_REG_WR: begin
        addr_raw  = {1'b0, cmd_i.reg_address};
        data_byte = cmd_i.reg_byte;
        last      = 1'b1;
      end
      scfg_pkg::ACT_RD_REQ: begin
        addr_raw  = {1'b0, cmd_i.reg_address};
        data_byte = scfg_pkg::ReadFill;
        last      = 1'b1;
      end
      scfg_pkg::ACT_SUB_CMD: begin
        if (idx_i != '0) begin
          addr_raw  = scfg_pkg::MbSubHi;
          data_byte = sub_hi;
          last      = 1'b1;
        end
      end
      scfg_pkg::ACT_MEM_WR1: begin
        case (idx_i)
          3'd1: begin
            addr_raw  = scfg_pkg::MbSubHi;
            data_byte = sub_hi;
          end
          3'd2: begin
            addr_raw  = scfg_pkg::MbDataLo;
            data_byte = val_lo;
          end
          3'd3: begin
            addr_raw  = scfg_pkg::MbChecksum;
            data_byte = ~sum3;
          end
          3'd4: begin
            addr_raw  = scfg_pkg::MbLength;
            data_byte = scfg_pkg::LenOneByte;
            last      = 1'b1;
          end
          default: begin
            addr_raw  = scfg_pkg::MbSubLo;
            data_byte = sub_lo;
          end
        endcase
      end
      scfg_pkg::ACT_MEM_WR2: begin
        case (idx_i)
          3'd1: begin
            addr_raw  = scfg_pkg::MbSubHi;
            data_byte = sub_hi;
          end
          3'd2: begin
            addr_raw  = scfg_pkg::MbDataLo;
            data_byte = val_lo;
          end
          3'd3: begin
            addr_raw  = scfg_pkg::MbDataHi;
            data_byte = val_hi;
          end
          3'd4: begin
            addr_raw  = scfg_pkg::MbChecksum;
            data_byte = ~sum4;
          end
          3'd5: begin
            addr_raw  = scfg_pkg::MbLength;
            data_byte = scfg_pkg::LenTwoByte;
            last      = 1'b1;
          end
          default: begin
            addr_raw  = scfg_pkg::MbSubLo;
            data_byte = sub_lo;
          end
        endcase
      end
      default: begin
        last = 1'b1;
      end
    endcase
  end

  // Set the write flag on everything but a read request, then add the CRC.
  always_comb begin
    frame_o.addr_byte = (cmd_i.action == scfg_pkg::ACT_RD_REQ)
                        ? addr_raw : (addr_raw | scfg_pkg::WriteFlag);
    frame_o.data_byte = data_byte;
    frame_o.crc       = scfg_pkg::crc8_frame(frame_o.addr_byte, data_byte);
    frame_o.last      = last;
  end

endmodule

// ===== sv/spi_command_frame_generator_unit.sv =====
// Top level of the SPI command framer: command register, slot counter, frame register.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------------------------
//  in      | input     | in_valid_i / in_stall_o | action, reg_address, reg_byte, sub/mem words
//  out     | output    | out_valid_o/out_stall_i | frame addr, data, crc, last_frame
//
// A command gives one frame per cycle unless out_stall_i holds it: 1 for register write or
// read request, 2 for a subcommand, 5 or 6 for a data-memory write; the slot counter over the command register
// counts the frames. The next command is taken in the cycle its predecessor's last frame
// moves to the output register. Unused action codes are taken and give no frames.
// Reset clears the valid flags and the counter; out_stall_i holds the frame register and,
// through it, the slot counter.
module spi_command_frame_generator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [6:0]  reg_address_i,
  input  logic [7:0]  reg_byte_i,
  input  logic [15:0] sub_address_i,
  input  logic [15:0] mem_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  frame_addr_byte_o,
  output logic [7:0]  frame_data_byte_o,
  output logic [7:0]  frame_crc_o,
  output logic        last_frame_o
);

  scfg_pkg::cmd_t       cmd_q;
  logic                 cmd_valid_q, cmd_valid_d;
  scfg_pkg::frame_idx_t idx_q, idx_d;
  scfg_pkg::frame_t     frame, out_q;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free, gen, cmd_done, in_take, act_legal;

  // Build the frame for the current slot.
  scfg_frame_sel u_sel (
    .cmd_i   (cmd_q),
    .idx_i   (idx_q),
    .frame_o (frame)
  );

  // Handshake control.
  always_comb begin
    act_legal = (action_i inside {scfg_pkg::ACT_REG_WR, scfg_pkg::ACT_RD_REQ,
                                  scfg_pkg::ACT_SUB_CMD, scfg_pkg::ACT_MEM_WR1,
                                  scfg_pkg::ACT_MEM_WR2});
    out_free   = !out_valid_q || !out_stall_i;
    gen        = cmd_valid_q && out_free;
    cmd_done   = gen && frame.last;
    in_stall_o = cmd_valid_q && !cmd_done;
    in_take    = in_valid_i && !in_stall_o;
  end

  // Advance the slot counter and command flag.
  always_comb begin
    cmd_valid_d = cmd_valid_q;
    idx_d       = idx_q;
    if (in_take && act_legal) begin
      cmd_valid_d = 1'b1;
      idx_d       = '0;
    end else if (cmd_done) begin
      cmd_valid_d = 1'b0;
      idx_d       = '0;
    end else if (gen) begin
      idx_d = idx_q + 1'b1;
    end
  end

  // Load on a new frame, drop once the word is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (gen) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cmd_valid_q <= cmd_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the command word and the frame payload.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q.action      <= scfg_pkg::action_e'(action_i);
      cmd_q.reg_address <= reg_address_i;
      cmd_q.reg_byte    <= reg_byte_i;
      cmd_q.sub_address <= sub_address_i;
      cmd_q.mem_value   <= mem_value_i;
    end
    if (gen) begin
      out_q <= frame;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign frame_addr_byte_o = out_q.addr_byte;
  assign frame_data_byte_o = out_q.data_byte;
  assign frame_crc_o       = out_q.crc;
  assign last_frame_o      = out_q.last;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the SPI command framer: random commands against a frame predictor.
module tb_top;

  localparam int unsigned RandCmds      = 130;
  localparam int unsigned WatchdogLimit = 400;
  localparam int unsigned HoldOffCycles = 80;
  localparam int unsigned HoldOffAfter  = 30;
  localparam int unsigned CalmTail      = 25;
  localparam int unsigned DrainCycles   = 12;

  // Action codes the framer takes but ignores.
  localparam logic [2:0] ActUnusedFirst = 3'd5;
  localparam logic [2:0] ActUnusedLast  = 3'd7;

  typedef struct packed {
    logic [2:0]  action;
    logic [6:0]  reg_address;
    logic [7:0]  reg_byte;
    logic [15:0] sub_address;
    logic [15:0] mem_value;
  } spi_cmd_t;

  typedef struct packed {
    logic [7:0] addr_byte;
    logic [7:0] data_byte;
    logic [7:0] crc;
    logic       last;
  } spi_frame_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [2:0]  action_i      = '0;
  logic [6:0]  reg_address_i = '0;
  logic [7:0]  reg_byte_i    = '0;
  logic [15:0] sub_address_i = '0;
  logic [15:0] mem_value_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [7:0]  frame_addr_byte_o;
  logic [7:0]  frame_data_byte_o;
  logic [7:0]  frame_crc_o;
  logic        last_frame_o;

  spi_cmd_t    cmd_backlog[$];
  spi_frame_t  frames_due[$];
  bit          cmd_taken    = 1'b0;
  int unsigned cmds_taken   = 0;
  int unsigned error_count  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_gap     = 0;
  int unsigned stall_left   = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;

  spi_command_frame_generator_unit u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .action_i          (action_i),
    .reg_address_i     (reg_address_i),
    .reg_byte_i        (reg_byte_i),
    .sub_address_i     (sub_address_i),
    .mem_value_i       (mem_value_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .frame_addr_byte_o (frame_addr_byte_o),
    .frame_data_byte_o (frame_data_byte_o),
    .frame_crc_o       (frame_crc_o),
    .last_frame_o      (last_frame_o)
  );

  // Free-running clock, 20 ns period.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Fold one byte into a CRC-8, polynomial 0x07, MSB first.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    r = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      r = r[7] ? ((r << 1) ^ scfg_pkg::CrcPoly) : (r << 1);
    end
    return r;
  endfunction

  function automatic void push_frame(input logic [7:0] a, input logic [7:0] d, input logic lst);
    spi_frame_t f;
    f.addr_byte = a;
    f.data_byte = d;
    f.crc       = crc8_update(crc8_update(8'h00, a), d);
    f.last      = lst;
    frames_due.push_back(f);
  endfunction

  // Expand one command into the frames it should put on the wire.
  function automatic void expand_command(input spi_cmd_t c);
    logic [7:0] sub_lo, sub_hi, val_lo, val_hi, sum;
    sub_lo = c.sub_address[7:0];
    sub_hi = c.sub_address[15:8];
    val_lo = c.mem_value[7:0];
    val_hi = c.mem_value[15:8];
    case (c.action)
      scfg_pkg::ACT_REG_WR: begin
        push_frame(scfg_pkg::WriteFlag | {1'b0, c.reg_address}, c.reg_byte, 1'b1);
      end
      scfg_pkg::ACT_RD_REQ: begin
        push_frame({1'b0, c.reg_address}, scfg_pkg::ReadFill, 1'b1);
      end
      scfg_pkg::ACT_SUB_CMD: begin
        push_frame(scfg_pkg::WriteFlag | scfg_pkg::MbSubLo, sub_lo, 1'b0);
        push_frame(scfg_pkg::WriteFlag | scfg_pkg::MbSubHi, sub_hi, 1'b1);
      end
      scfg_pkg::ACT_MEM_WR1: begin
        sum = sub_lo + sub_hi + val_lo;
        push_frame(scfg_pkg::WriteFlag | scfg_pkg::MbSubLo, sub_lo, 1'b0);
        push_frame(scfg_pkg::WriteFlag | scfg_pkg::MbSubHi, sub_hi, 1'b0);
        push_frame(scfg_pkg::WriteFlag | scfg_pkg::MbDataLo, val_lo, 1'b0);
        push_frame(scfg_pkg::WriteFlag | scfg_pkg::MbChecksum, ~sum, 1'b0);
        push_frame(scfg_pkg::WriteFlag | scfg_pkg::MbLength, scfg_pkg::LenOneByte, 1'b1);
      end
      scfg_pkg::ACT_MEM_WR2: begin
        sum = sub_lo + sub_hi + val_lo + val_hi;
        push_frame(scfg_pkg::WriteFlag | scfg_pkg::MbSubLo, sub_lo, 1'b0);
        push_frame(scfg_pkg::WriteFlag | scfg_pkg::MbSubHi, sub_hi, 1'b0);
        push_frame(scfg_pkg::WriteFlag | scfg_pkg::MbDataLo, val_lo, 1'b0);
        push_frame(scfg_pkg::WriteFlag | scfg_pkg::MbDataHi, val_hi, 1'b0);
        push_frame(scfg_pkg::WriteFlag | scfg_pkg::MbChecksum, ~sum, 1'b0);
        push_frame(scfg_pkg::WriteFlag | scfg_pkg::MbLength, scfg_pkg::LenTwoByte, 1'b1);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void queue_cmd(input logic [2:0] act, input logic [6:0] ra,
                                    input logic [7:0] rb, input logic [15:0] sa,
                                    input logic [15:0] mv);
    spi_cmd_t c;
    c.action      = act;
    c.reg_address = ra;
    c.reg_byte    = rb;
    c.sub_address = sa;
    c.mem_value   = mv;
    cmd_backlog.push_back(c);
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Command driver: advance after each accepted word, idle in random bursts.
  always @(negedge clk_i) begin
    spi_cmd_t c;
    if (rst_ni && (!in_valid_i || cmd_taken)) begin
      cmd_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (cmd_backlog.size() >= CalmTail && $urandom_range(0, 3) == 0) begin
        send_gap = $urandom_range(0, 14);
        in_valid_i <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        c = cmd_backlog.pop_front();
        in_valid_i    <= 1'b1;
        action_i      <= c.action;
        reg_address_i <= c.reg_address;
        reg_byte_i    <= c.reg_byte;
        sub_address_i <= c.sub_address;
        mem_value_i   <= c.mem_value;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Frame receiver: random stall bursts, one long hold-off, none in the tail.
  always @(negedge clk_i) begin
    if (!hold_done && cmds_taken >= HoldOffAfter) begin
      hold_done = 1'b1;
      hold_left = HoldOffCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (cmd_backlog.size() < CalmTail) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 14);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Monitor: predict on each accepted command, check each accepted frame.
  always @(posedge clk_i) begin
    spi_cmd_t   got_cmd;
    spi_frame_t want;
    bit         moved;
    moved = 1'b0;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      got_cmd.action      = action_i;
      got_cmd.reg_address = reg_address_i;
      got_cmd.reg_byte    = reg_byte_i;
      got_cmd.sub_address = sub_address_i;
      got_cmd.mem_value   = mem_value_i;
      expand_command(got_cmd);
      cmd_taken = 1'b1;
      cmds_taken++;
      moved = 1'b1;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      moved = 1'b1;
      if (frames_due.size() == 0) begin
        report_mismatch($sformatf("unexpected frame %02h %02h %02h last %0b",
                                  frame_addr_byte_o, frame_data_byte_o, frame_crc_o,
                                  last_frame_o));
      end else begin
        want = frames_due.pop_front();
        if (frame_addr_byte_o !== want.addr_byte) begin
          report_mismatch($sformatf("addr byte %02h, want %02h",
                                    frame_addr_byte_o, want.addr_byte));
        end
        if (frame_data_byte_o !== want.data_byte) begin
          report_mismatch($sformatf("data byte %02h, want %02h (addr %02h)",
                                    frame_data_byte_o, want.data_byte, want.addr_byte));
        end
        if (frame_crc_o !== want.crc) begin
          report_mismatch($sformatf("crc %02h, want %02h (addr %02h)",
                                    frame_crc_o, want.crc, want.addr_byte));
        end
        if (last_frame_o !== want.last) begin
          report_mismatch($sformatf("last_frame %0b, want %0b (addr %02h)",
                                    last_frame_o, want.last, want.addr_byte));
        end
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin
    @(posedge clk_i);
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk_i);
    end
    $display("FAILED: results differ");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    spi_cmd_t    c;
    int unsigned n;

    // Field extremes, every action, ignored codes, and unused fields set.
    queue_cmd(scfg_pkg::ACT_REG_WR, 7'h00, 8'h00, 16'h0000, 16'h0000);
    queue_cmd(scfg_pkg::ACT_REG_WR, 7'h7F, 8'hFF, 16'hFFFF, 16'hFFFF);
    queue_cmd(scfg_pkg::ACT_REG_WR, 7'h2A, 8'hA5, 16'h5A5A, 16'hC3C3);
    queue_cmd(scfg_pkg::ACT_RD_REQ, 7'h00, 8'h00, 16'h0000, 16'h0000);
    queue_cmd(scfg_pkg::ACT_RD_REQ, 7'h7F, 8'hFF, 16'hFFFF, 16'hFFFF);
    queue_cmd(scfg_pkg::ACT_SUB_CMD, 7'h00, 8'h00, 16'h0000, 16'h0000);
    queue_cmd(scfg_pkg::ACT_SUB_CMD, 7'h7F, 8'hFF, 16'hFFFF, 16'hFFFF);
    queue_cmd(scfg_pkg::ACT_SUB_CMD, 7'h55, 8'h33, 16'h1234, 16'hBEEF);
    queue_cmd(scfg_pkg::ACT_MEM_WR1, 7'h00, 8'h00, 16'h0000, 16'h0000);
    queue_cmd(scfg_pkg::ACT_MEM_WR1, 7'h7F, 8'hFF, 16'hFFFF, 16'hFFFF);
    queue_cmd(scfg_pkg::ACT_MEM_WR1, 7'h11, 8'h22, 16'h4321, 16'hAB80);
    queue_cmd(scfg_pkg::ACT_MEM_WR2, 7'h00, 8'h00, 16'h0000, 16'h0000);
    queue_cmd(scfg_pkg::ACT_MEM_WR2, 7'h7F, 8'hFF, 16'hFFFF, 16'hFFFF);
    queue_cmd(scfg_pkg::ACT_MEM_WR2, 7'h01, 8'h80, 16'h8001, 16'h7FFE);
    queue_cmd(ActUnusedFirst, 7'h7F, 8'hFF, 16'hFFFF, 16'hFFFF);
    queue_cmd(ActUnusedFirst + 3'd1, 7'h00, 8'h00, 16'h0000, 16'h0000);
    queue_cmd(ActUnusedLast, 7'h40, 8'h81, 16'hF00F, 16'h0FF0);
    queue_cmd(scfg_pkg::ACT_REG_WR, 7'h40, 8'h01, 16'h0000, 16'h0000);
    queue_cmd(scfg_pkg::ACT_MEM_WR2, 7'h00, 8'h00, 16'h00FF, 16'hFF00);

    // Random commands, a few with ignored codes mixed in.
    n = 0;
    while (n < RandCmds) begin
      if ($urandom_range(0, 15) == 0) begin
        c.action = 3'($urandom_range(ActUnusedFirst, ActUnusedLast));
      end else begin
        c.action = 3'($urandom_range(scfg_pkg::ACT_REG_WR, scfg_pkg::ACT_MEM_WR2));
      end
      c.reg_address = 7'($urandom);
      c.reg_byte    = 8'($urandom);
      c.sub_address = 16'($urandom);
      c.mem_value   = 16'($urandom);
      cmd_backlog.push_back(c);
      if (c.action <= scfg_pkg::ACT_MEM_WR2) begin
        n++;
      end
    end

    // Hold reset, then release it on a falling edge.
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Drain: all commands in, all frames out, then a short settle.
    while (cmd_backlog.size() != 0 || in_valid_i) begin
      @(posedge clk_i);
    end
    while (frames_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0 && frames_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
